>>> sv/esrp_pkg.sv
// ----------------------------------------------------------------------------
// esrp_pkg
// Shared widths, constants and types for the error statistics block.
// ----------------------------------------------------------------------------
package esrp_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int MAX_COUNT_LOG2 = 20;
   localparam int SSE_BITS       = 52;
   localparam int CNT_BITS       = MAX_COUNT_LOG2 + 1;
   localparam int MSE_BITS       = SSE_BITS + 8;
   localparam int RANGE_BITS     = SAMPLE_BITS + 1;
   localparam int RMSE_BITS      = 20;
   localparam int LOG_BITS       = 22;
   localparam logic [31:0] PSNR_K = 32'd808071242;

   localparam logic [1:0] STATUS_NORMAL    = 2'd0;
   localparam logic [1:0] STATUS_IDENTICAL = 2'd1;
   localparam logic [1:0] STATUS_MSE_ZERO  = 2'd2;
   localparam logic [1:0] STATUS_RANGE_ZERO = 2'd3;

   // running statistics of one set
   typedef struct packed {
      logic [SSE_BITS-1:0]           sse;
      logic [CNT_BITS-1:0]           count;
      logic signed [SAMPLE_BITS-1:0] min;
      logic signed [SAMPLE_BITS-1:0] max;
      logic [SAMPLE_BITS-1:0]        largest;
      logic                          all_eq;
   } acc_type;

endpackage

>>> sv/esrp_accum.sv
// ----------------------------------------------------------------------------
// esrp_accum
// Per-pair accumulation of squared error, largest error, min, max and count.
// ----------------------------------------------------------------------------
module esrp_accum import esrp_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic                          last,
   input  logic signed [SAMPLE_BITS-1:0] ref_s,
   input  logic signed [SAMPLE_BITS-1:0] tst_s,
   output acc_type                       stats_next
);

   localparam logic [SSE_BITS-1:0] SSE_LIMIT = {SSE_BITS{1'b1}};
   localparam logic [CNT_BITS-1:0] CNT_LIMIT = CNT_BITS'(1) << MAX_COUNT_LOG2;

   acc_type acc_ff, acc_in, acc_rst;

   logic signed [SAMPLE_BITS:0]  dif;
   logic [SAMPLE_BITS-1:0]       mag;
   logic [2*SAMPLE_BITS-1:0]     sq;
   logic [SSE_BITS:0]            sum;

   // reset values of the statistics
   always_comb begin
      acc_rst         = '0;
      acc_rst.min     = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      acc_rst.max     = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      acc_rst.all_eq  = 1'b1;
   end

   // absolute difference and its square
   assign dif = {ref_s[SAMPLE_BITS-1], ref_s} - {tst_s[SAMPLE_BITS-1], tst_s};
   assign mag = dif[SAMPLE_BITS] ? SAMPLE_BITS'(-dif) : dif[SAMPLE_BITS-1:0];
   assign sq  = mag * mag;
   assign sum = {1'b0, acc_ff.sse} + (SSE_BITS+1)'(sq);

   // statistics including the current pair
   always_comb begin
      stats_next         = acc_ff;
      stats_next.sse     = sum[SSE_BITS] ? SSE_LIMIT : sum[SSE_BITS-1:0];
      stats_next.count   = (acc_ff.count < CNT_LIMIT) ? acc_ff.count + 1'b1 : acc_ff.count;
      if (ref_s < acc_ff.min) stats_next.min = ref_s;
      if (ref_s > acc_ff.max) stats_next.max = ref_s;
      if (mag > acc_ff.largest) stats_next.largest = mag;
      if (ref_s != tst_s) stats_next.all_eq = 1'b0;
   end

   assign acc_in = !take ? acc_ff : (last ? acc_rst : stats_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= acc_rst;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

>>> sv/error_stats_rmse_psnr_top.sv
// A pair without the last mark is added to the registered statistics, and pairs stream at
// one per cycle while req_stall is low. A last pair starts the final pass: a bit-serial divide,
// a bit-serial square root, then for a normal result two logarithms (load, normalize shift,
// 16 squarings) and three more steps (difference, multiply, finish); a special case goes from the root to finish.
// Input is stalled during the final pass, whose finish step also waits while rsp_stall holds an
// earlier result. Reset is synchronous, clears the statistics and drops any pending result.
// ----------------------------------------------------------------------------
// error_stats_rmse_psnr_top
// Error metrics (rmse, largest error, min, max, psnr) over sets of sample pairs.
// ----------------------------------------------------------------------------
module error_stats_rmse_psnr_top import esrp_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_reference_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_test_sample,
   input  logic                          req_last_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [RMSE_BITS-1:0]          rsp_rmse_q4,
   output logic [15:0]                   rsp_max_abs_error,
   output logic signed [15:0]            rsp_psnr_q8,
   output logic signed [15:0]            rsp_ref_min,
   output logic signed [15:0]            rsp_ref_max,
   output logic [1:0]                    rsp_psnr_status
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIV   = 4'd1;
   localparam logic [3:0] S_SQRT  = 4'd2;
   localparam logic [3:0] S_LOGLD = 4'd3;
   localparam logic [3:0] S_NORM  = 4'd4;
   localparam logic [3:0] S_LOGSQ = 4'd5;
   localparam logic [3:0] S_DIFF  = 4'd6;
   localparam logic [3:0] S_MUL   = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;

   localparam int ROOT_BITS = MSE_BITS / 2;
   localparam int SREM_BITS = ROOT_BITS + 2;
   localparam int DREM_BITS = CNT_BITS + 1;
   localparam int D_BITS    = LOG_BITS + 3;

   logic [3:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   acc_type    snap_ff, snap_in, stats_next;
   logic       take, take_last, out_free;

   logic [MSE_BITS-1:0]  num_ff, num_in, mse_ff, mse_in;
   logic [DREM_BITS-1:0] drem_ff, drem_in, drem_s;
   logic [SREM_BITS-1:0] srem_ff, srem_in, srem_s, trial;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic                 dge, sge;

   logic [63:0] x_ff, x_in;
   logic [5:0]  e_ff, e_in;
   logic [31:0] m_ff, m_in;
   logic [15:0] frac_ff, frac_in;
   logic        sel_ff, sel_in;
   logic [LOG_BITS-1:0] lr_ff, lr_in, lm_ff, lm_in;
   logic [32:0] m2;

   logic signed [D_BITS-1:0] d;
   logic [D_BITS-2:0]        mag_ff, mag_in;
   logic                     neg_ff, neg_in;
   logic [16:0]              q_ff, q_in;
   logic [63:0]              prod, prod_r;
   logic [31:0]              mul_a, mul_b;

   logic [RANGE_BITS-1:0]    range;
   logic                     special;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RMSE_BITS-1:0]     rmse_ff, rmse_in;
   logic [15:0]              maxe_ff, maxe_in;
   logic signed [15:0]       psnr_ff, psnr_in, rmin_ff, rmin_in, rmax_ff, rmax_in;
   logic [1:0]               stat_ff, stat_in;

   // input transfer and per-pair accumulation
   assign req_stall = (state_ff != S_IDLE);
   assign take      = req_valid && !req_stall;
   assign take_last = take && req_last_sample;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   esrp_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .last       (req_last_sample),
      .ref_s      (req_reference_sample),
      .tst_s      (req_test_sample),
      .stats_next (stats_next)
   );

   // divide, root and log step logic
   assign drem_s = {drem_ff[DREM_BITS-2:0], num_ff[MSE_BITS-1]};
   assign dge    = drem_s >= {1'b0, snap_ff.count};
   assign srem_s = {srem_ff[SREM_BITS-3:0], num_ff[MSE_BITS-1:MSE_BITS-2]};
   assign trial  = {root_ff, 2'b01};
   assign sge    = srem_s >= trial;

   assign range   = RANGE_BITS'({snap_ff.max[SAMPLE_BITS-1], snap_ff.max})
                    - RANGE_BITS'({snap_ff.min[SAMPLE_BITS-1], snap_ff.min});
   assign special = snap_ff.all_eq || (mse_ff == '0) || (range == '0);

   // shared multiplier
   assign mul_a  = (state_ff == S_MUL) ? 32'(mag_ff) : m_ff;
   assign mul_b  = (state_ff == S_MUL) ? PSNR_K : m_ff;
   assign prod   = mul_a * mul_b;
   assign prod_r = prod + (64'd1 << 35);
   assign m2     = prod[63:31];

   assign d = D_BITS'({lr_ff, 1'b0}) + D_BITS'(32'd524288) - D_BITS'(lm_ff);

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      snap_in  = snap_ff;
      num_in   = num_ff;
      mse_in   = mse_ff;
      drem_in  = drem_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      x_in     = x_ff;
      e_in     = e_ff;
      m_in     = m_ff;
      frac_in  = frac_ff;
      sel_in   = sel_ff;
      lr_in    = lr_ff;
      lm_in    = lm_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      q_in     = q_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rmse_in  = rmse_ff;
      maxe_in  = maxe_ff;
      psnr_in  = psnr_ff;
      rmin_in  = rmin_ff;
      rmax_in  = rmax_ff;
      stat_in  = stat_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (take_last) begin
               snap_in  = stats_next;
               num_in   = {stats_next.sse, 8'd0};
               drem_in  = '0;
               cnt_in   = 6'(MSE_BITS - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            drem_in = dge ? drem_s - {1'b0, snap_ff.count} : drem_s;
            num_in  = {num_ff[MSE_BITS-2:0], dge};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               mse_in   = num_in;
               srem_in  = '0;
               root_in  = '0;
               cnt_in   = 6'(ROOT_BITS - 1);
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            srem_in = sge ? srem_s - trial : srem_s;
            root_in = {root_ff[ROOT_BITS-2:0], sge};
            num_in  = {num_ff[MSE_BITS-3:0], 2'b00};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               sel_in   = 1'b0;
               state_in = special ? S_FIN : S_LOGLD;
            end
         end
         S_LOGLD: begin
            x_in     = sel_ff ? 64'(mse_ff) : 64'(range);
            e_in     = 6'd63;
            state_in = S_NORM;
         end
         S_NORM: begin
            if (x_ff[63]) begin
               m_in     = x_ff[63:32];
               frac_in  = '0;
               cnt_in   = 6'd15;
               state_in = S_LOGSQ;
            end else begin
               x_in = {x_ff[62:0], 1'b0};
               e_in = e_ff - 1'b1;
            end
         end
         S_LOGSQ: begin
            frac_in = {frac_ff[14:0], m2[32]};
            m_in    = m2[32] ? m2[32:1] : m2[31:0];
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               if (sel_ff) begin
                  lm_in    = {e_ff, frac_in};
                  state_in = S_DIFF;
               end else begin
                  lr_in    = {e_ff, frac_in};
                  sel_in   = 1'b1;
                  state_in = S_LOGLD;
               end
            end
         end
         S_DIFF: begin
            neg_in   = d[D_BITS-1];
            mag_in   = d[D_BITS-1] ? (D_BITS-1)'(-d) : d[D_BITS-2:0];
            state_in = S_MUL;
         end
         S_MUL: begin
            q_in     = prod_r[52:36];
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rmse_in  = (root_ff[ROOT_BITS-1:RMSE_BITS] != '0) ? {RMSE_BITS{1'b1}}
                          : root_ff[RMSE_BITS-1:0];
               maxe_in  = snap_ff.largest;
               rmin_in  = snap_ff.min;
               rmax_in  = snap_ff.max;
               if (snap_ff.all_eq) begin
                  stat_in = STATUS_IDENTICAL;
                  rmse_in = '0;
                  maxe_in = '0;
                  psnr_in = 16'sd32767;
               end else if (mse_ff == '0) begin
                  stat_in = STATUS_MSE_ZERO;
                  psnr_in = 16'sd32767;
               end else if (range == '0) begin
                  stat_in = STATUS_RANGE_ZERO;
                  psnr_in = 16'h8000;
               end else begin
                  stat_in = STATUS_NORMAL;
                  if (neg_ff)
                     psnr_in = (q_ff >= 17'd32768) ? 16'h8000 : -$signed(q_ff[15:0]);
                  else
                     psnr_in = (q_ff >= 17'd32767) ? 16'sd32767 : $signed(q_ff[15:0]);
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      snap_ff <= snap_in;
      num_ff  <= num_in;
      mse_ff  <= mse_in;
      drem_ff <= drem_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      x_ff    <= x_in;
      e_ff    <= e_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      sel_ff  <= sel_in;
      lr_ff   <= lr_in;
      lm_ff   <= lm_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      q_ff    <= q_in;
      rmse_ff <= rmse_in;
      maxe_ff <= maxe_in;
      psnr_ff <= psnr_in;
      rmin_ff <= rmin_in;
      rmax_ff <= rmax_in;
      stat_ff <= stat_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rmse_q4       = rmse_ff;
   assign rsp_max_abs_error = maxe_ff;
   assign rsp_psnr_q8       = psnr_ff;
   assign rsp_ref_min       = rmin_ff;
   assign rsp_ref_max       = rmax_ff;
   assign rsp_psnr_status   = stat_ff;

endmodule

>>> sv/esrp_checker.sv
// ----------------------------------------------------------------------------
// esrp_checker
// Port-level checks of the error statistics block, bound to the top level.
// ----------------------------------------------------------------------------
module esrp_checker import esrp_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic signed [SAMPLE_BITS-1:0] req_reference_sample,
   input logic signed [SAMPLE_BITS-1:0] req_test_sample,
   input logic                          req_last_sample,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [RMSE_BITS-1:0]          rsp_rmse_q4,
   input logic [15:0]                   rsp_max_abs_error,
   input logic signed [15:0]            rsp_psnr_q8,
   input logic signed [15:0]            rsp_ref_min,
   input logic signed [15:0]            rsp_ref_max,
   input logic [1:0]                    rsp_psnr_status
);

   // no result right after reset
   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_psnr_q8) && $stable(rsp_rmse_q4))
      else $error("stalled result changed");

   // last pair starts the final pass
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_sample |=> req_stall)
      else $error("input not stalled after last pair");

   // identical sets report zero error
   a_identical: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_psnr_status == STATUS_IDENTICAL |->
      rsp_rmse_q4 == '0 && rsp_max_abs_error == '0 && rsp_psnr_q8 == 16'sd32767)
      else $error("identical set result wrong");

   // zero range means min equals max
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_psnr_status == STATUS_RANGE_ZERO |->
      rsp_ref_min == rsp_ref_max && rsp_psnr_q8 == 16'sh8000)
      else $error("zero range result wrong");

endmodule

bind error_stats_rmse_psnr_top esrp_checker u_esrp_checker (.*);

>>> tb/error_stats_rmse_psnr_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// error_stats_rmse_psnr_top_tb
// Drives sets of sample pairs into the error statistics block. An in-bench
// model predicts rmse, largest error, min, max, psnr and status for each set,
// and a scoreboard checks every result transfer in order.
// ----------------------------------------------------------------------------
module error_stats_rmse_psnr_top_tb import esrp_pkg::*;;

   // expected result of one set
   typedef struct {
      logic [19:0]        rmse;
      logic [15:0]        largest;
      logic signed [15:0] psnr;
      logic signed [15:0] rmin;
      logic signed [15:0] rmax;
      logic [1:0]         status;
   } metrics_type;

   // set statistics model with an ordered store of expected metrics
   class metrics_board_type;
      metrics_type pending[$];
      int          errors;
      logic [63:0] sse;
      logic [63:0] cnt;
      logic [15:0] big;
      longint      lo, hi;
      bit          same;

      function void clear();
         sse = 0; cnt = 0; big = 0; lo = 32767; hi = -32768; same = 1;
      endfunction

      function logic [63:0] root(logic [63:0] x);
         logic [63:0] res, b;
         res = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= res + b) begin
               x = x - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function longint lg2(logic [63:0] x);
         int          e;
         logic [63:0] m;
         longint      fr;
         fr = 0; e = 0;
         if (x == 0) x = 1;
         while (e < 63 && (x >> (e + 1)) != 0) e++;
         m = (e >= 31) ? x >> (e - 31) : x << (31 - e);
         for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 31;
            fr = fr << 1;
            if (m >= 64'h1_0000_0000) begin
               m = m >> 1;
               fr = fr | 1;
            end
         end
         return longint'(e) * 65536 + fr;
      endfunction

      // note an accepted input pair
      function void note_pair(logic signed [15:0] r, logic signed [15:0] t, bit last);
         longint      d;
         logic [63:0] sq, mse, rm, rng, mag, q;
         metrics_type m;
         longint      p;
         d = (r >= t) ? longint'(r) - t : longint'(t) - r;
         sq = d * d;
         if (r < lo) lo = r;
         if (r > hi) hi = r;
         if (d > big) big = 16'(d);
         if (r != t) same = 0;
         if (sq > (64'd1 << 52) - 1 - sse) sse = (64'd1 << 52) - 1;
         else sse = sse + sq;
         if (cnt < (64'd1 << MAX_COUNT_LOG2)) cnt++;
         if (!last) return;
         mse = (sse << 8) / cnt;
         rm = root(mse);
         if (rm > 1048575) rm = 1048575;
         rng = hi - lo;
         if (same) begin
            m.status = STATUS_IDENTICAL; rm = 0; p = 32767;
         end else if (mse == 0) begin
            m.status = STATUS_MSE_ZERO; p = 32767;
         end else if (rng == 0) begin
            m.status = STATUS_RANGE_ZERO; p = -32768;
         end else begin
            longint dd;
            dd = 2 * lg2(rng) + 8 * 65536 - lg2(mse);
            mag = (dd < 0) ? -dd : dd;
            q = (mag * PSNR_K + (64'd1 << 35)) >> 36;
            if (q > 32768) q = 32768;
            p = (dd < 0) ? -longint'(q) : longint'(q);
            if (p > 32767) p = 32767;
            m.status = STATUS_NORMAL;
         end
         m.rmse = 20'(rm);
         m.largest = same ? 16'd0 : big;
         m.psnr = 16'(p);
         m.rmin = 16'(lo);
         m.rmax = 16'(hi);
         pending.push_back(m);
         clear();
      endfunction

      // check a result transfer against the oldest expectation
      function void check(metrics_type a);
         metrics_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result rmse %0d", $time, a.rmse);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.rmse !== e.rmse) begin
            $display("%0t: rmse exp %0d got %0d", $time, e.rmse, a.rmse); errors++;
         end
         if (a.largest !== e.largest) begin
            $display("%0t: max_abs_error exp %0d got %0d", $time, e.largest, a.largest);
            errors++;
         end
         if (a.psnr !== e.psnr) begin
            $display("%0t: psnr exp %0d got %0d", $time, e.psnr, a.psnr); errors++;
         end
         if (a.rmin !== e.rmin) begin
            $display("%0t: ref_min exp %0d got %0d", $time, e.rmin, a.rmin); errors++;
         end
         if (a.rmax !== e.rmax) begin
            $display("%0t: ref_max exp %0d got %0d", $time, e.rmax, a.rmax); errors++;
         end
         if (a.status !== e.status) begin
            $display("%0t: status exp %0d got %0d", $time, e.status, a.status); errors++;
         end
      endfunction
   endclass

   logic                          clock = 0;
   logic                          reset = 1;
   logic                          req_valid = 0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_reference_sample = 0;
   logic signed [SAMPLE_BITS-1:0] req_test_sample = 0;
   logic                          req_last_sample = 0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1;
   logic [RMSE_BITS-1:0]          rsp_rmse_q4;
   logic [15:0]                   rsp_max_abs_error;
   logic signed [15:0]            rsp_psnr_q8;
   logic signed [15:0]            rsp_ref_min;
   logic signed [15:0]            rsp_ref_max;
   logic [1:0]                    rsp_psnr_status;

   metrics_board_type board = new();
   bit           no_idle = 0;
   bit           hold_off = 0;
   int           quiet = 0;
   int           sets_done = 0;

   error_stats_rmse_psnr_top DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // offer one pair, with a random gap first
   task automatic send_pair(logic signed [15:0] r, logic signed [15:0] t, bit last);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_reference_sample <= r;
      req_test_sample <= t;
      req_last_sample <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_pair(r, t, last);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick();
      case ($urandom_range(0, 5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         default: return 16'($urandom);
      endcase
   endfunction

   // receiver: random stalls, with one long hold-off on request
   initial begin
      int w;
      @(negedge reset);
      forever begin
         if (hold_off) begin
            rsp_stall <= 1;
            repeat (600) @(posedge clock);
            hold_off = 0;
         end
         w = no_idle ? 0 : $urandom_range(0, 11);
         if (w != 0) begin
            rsp_stall <= 1;
            repeat (w) @(posedge clock);
         end
         rsp_stall <= 0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // result monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            metrics_type a;
            a.rmse = rsp_rmse_q4;
            a.largest = rsp_max_abs_error;
            a.psnr = rsp_psnr_q8;
            a.rmin = rsp_ref_min;
            a.rmax = rsp_ref_max;
            a.status = rsp_psnr_status;
            board.check(a);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet <= 0;
         else quiet <= quiet + 1;
         if (quiet > 5000) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      int len;
      board.clear();
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // identical set
      send_pair(16'sd5, 16'sd5, 0);
      send_pair(-16'sd7, -16'sd7, 1);
      // single pair: range zero
      send_pair(16'sd100, 16'sd0, 1);
      // mse floor to zero: one unit error over many pairs
      for (int i = 0; i < 300; i++) send_pair(16'(i), 16'(i + (i == 0)), i == 299);
      // full-scale extremes
      send_pair(16'sh7fff, 16'sh8000, 0);
      send_pair(16'sh8000, 16'sh7fff, 1);
      send_pair(16'sh8000, 16'sh8000, 0);
      send_pair(16'sh7fff, 16'sh7ffe, 1);
      // range zero with error
      send_pair(-16'sd3, 16'sd9, 0);
      send_pair(-16'sd3, -16'sd3, 1);
      send_pair(16'sd1000, 16'sd1001, 0);
      send_pair(-16'sd1000, -16'sd990, 1);
      drain();

      // receiver holds off while sender keeps offering sets
      hold_off = 1;
      for (int s = 0; s < 6; s++) begin
         len = $urandom_range(1, 4);
         for (int i = 0; i < len; i++) send_pair(16'($urandom), 16'($urandom), i == len - 1);
      end
      drain();

      // random sets, some without idling
      for (int n = 0; n < 900; ) begin
         no_idle = ($urandom_range(0, 7) == 0);
         len = $urandom_range(1, 24);
         for (int i = 0; i < len; i++) begin
            logic signed [15:0] r, t;
            r = pick();
            case ($urandom_range(0, 3))
               0: t = r;
               1: t = r + $signed(16'($urandom_range(0, 6)) - 16'sd3);
               default: t = pick();
            endcase
            send_pair(r, t, i == len - 1);
         end
         n += len;
         if ($urandom_range(0, 9) == 0) drain();
      end
      no_idle = 0;
      drain();
      repeat (300) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/esrp_pkg.sv
sv/esrp_accum.sv
sv/error_stats_rmse_psnr_top.sv
sv/esrp_checker.sv
tb/error_stats_rmse_psnr_top_tb.sv
